### src/ffdl_pkg.sv
package ffdl_pkg;

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_ADDR_W-1:0] REG_FIXED_DELAY    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FEEDBACK_LEVEL = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PER_SAMPLE     = 2'd2;

  localparam logic [23:0] FIXED_DELAY_RST = 24'd12288000;
  localparam logic [16:0] LEVEL_UNITY     = 17'd65536;

  // tap codes, oldest neighbor first
  localparam logic [1:0] TAP_Y0 = 2'd0;
  localparam logic [1:0] TAP_Y1 = 2'd1;
  localparam logic [1:0] TAP_Y2 = 2'd2;
  localparam logic [1:0] TAP_Y3 = 2'd3;

  typedef struct packed {
    logic       load_in;
    logic       clr_wr;
    logic       clr_fb_en;
    logic       fb_rd;
    logic       wr_x;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       cap_en;
    logic [1:0] cap_sel;
    logic       mul1;
    logic       mul2;
    logic       mul3;
    logic       res_ld;
    logic       fbk_mul;
    logic       fb_wr;
    logic       out_ld;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_busy;
  } status_t;

endpackage

### src/fractional_feedback_delay_line_top.sv
// Fractional feedback delay line. Each input sample plus the feedback value
// saved FB_DEPTH samples earlier is written to a STORE_DEPTH-entry ring;
// the output is a Catmull-Rom interpolation at (delay, 8 fraction bits)
// samples back, clamped to 2.0 .. STORE_DEPTH-2, saturated. The delay comes
// from register 0, or from each item when register 2 is set; register 1 is
// the feedback gain (65536 = 1.0). The next item is taken only once the
// last result has been loaded to the output, so items never overlap. Each
// item takes a feedback read, the store write and four neighbor reads on
// the single-port delay memory, three multiply steps, rounding, the
// feedback product and its write-back, then the output load.
// A result still waiting at the output holds the next one in the core.
// After reset, and for any item with clear_store set, the delay memory is
// zeroed one entry per cycle, and no item is accepted until all STORE_DEPTH
// entries are cleared (configuration writes are still taken).
module fractional_feedback_delay_line_top #(
  parameter int STORE_DEPTH = 65536,
  parameter int FB_DEPTH    = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // sample_in, delay_in (24), zero fill
  input  logic [((SAMPLE_BITS+24+7)/8)*8-1:0] s_tdata,
  // clear_store
  input  logic [0:0]                          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // sample_out, zero fill
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,
  input  logic                                cfg_we,
  input  logic [ffdl_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [ffdl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int OW = ((SAMPLE_BITS + 7) / 8) * 8;

  ffdl_pkg::cmd_t    cmd;
  ffdl_pkg::status_t stat;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  ffdl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_clear (s_tuser[0]),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ffdl_datapath #(
    .STORE_DEPTH (STORE_DEPTH),
    .FB_DEPTH    (FB_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .sample_in  ($signed(s_tdata[SAMPLE_BITS-1:0])),
    .delay_in   (s_tdata[SAMPLE_BITS+23:SAMPLE_BITS]),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .sample_out (sample_out)
  );

  assign m_tdata = OW'($unsigned(sample_out));

endmodule

### src/ffdl_ctrl.sv
module ffdl_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_clear,
  output logic             in_ready,
  input  ffdl_pkg::status_t stat,
  output ffdl_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_FBRD  = 4'd2;
  localparam logic [3:0] S_WRITE = 4'd3;
  localparam logic [3:0] S_RD0   = 4'd4;
  localparam logic [3:0] S_RD1   = 4'd5;
  localparam logic [3:0] S_RD2   = 4'd6;
  localparam logic [3:0] S_RD3   = 4'd7;
  localparam logic [3:0] S_CAP3  = 4'd8;
  localparam logic [3:0] S_MUL1  = 4'd9;
  localparam logic [3:0] S_MUL2  = 4'd10;
  localparam logic [3:0] S_MUL3  = 4'd11;
  localparam logic [3:0] S_RES   = 4'd12;
  localparam logic [3:0] S_FBK   = 4'd13;
  localparam logic [3:0] S_FBW   = 4'd14;
  localparam logic [3:0] S_OUT   = 4'd15;

  logic [3:0] state, state_next;
  logic       init, init_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      init  <= 1'b1;
    end else begin
      state <= state_next;
      init  <= init_next;
    end
  end

  always_comb begin
    state_next = state;
    init_next  = init;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = in_clear ? S_CLEAR : S_FBRD;
        end
      end
      S_CLEAR: begin
        cmd.clr_wr    = 1'b1;
        cmd.clr_fb_en = init;
        if (stat.clr_last) begin
          init_next  = 1'b0;
          state_next = init ? S_IDLE : S_FBRD;
        end
      end
      S_FBRD: begin
        cmd.fb_rd  = 1'b1;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        cmd.wr_x   = 1'b1;
        state_next = S_RD0;
      end
      S_RD0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ffdl_pkg::TAP_Y0;
        state_next = S_RD1;
      end
      S_RD1: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = ffdl_pkg::TAP_Y1;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = ffdl_pkg::TAP_Y0;
        state_next  = S_RD2;
      end
      S_RD2: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = ffdl_pkg::TAP_Y2;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = ffdl_pkg::TAP_Y1;
        state_next  = S_RD3;
      end
      S_RD3: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = ffdl_pkg::TAP_Y3;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = ffdl_pkg::TAP_Y2;
        state_next  = S_CAP3;
      end
      S_CAP3: begin
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = ffdl_pkg::TAP_Y3;
        state_next  = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul3   = 1'b1;
        state_next = S_RES;
      end
      S_RES: begin
        cmd.res_ld = 1'b1;
        state_next = S_FBK;
      end
      S_FBK: begin
        cmd.fbk_mul = 1'b1;
        state_next  = S_FBW;
      end
      S_FBW: begin
        cmd.fb_wr  = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.out_ld = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### src/ffdl_datapath.sv
module ffdl_datapath #(
  parameter int STORE_DEPTH = 65536,
  parameter int FB_DEPTH    = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ffdl_pkg::cmd_t                    cmd,
  output ffdl_pkg::status_t                 stat,
  input  logic signed [SAMPLE_BITS-1:0]     sample_in,
  input  logic [23:0]                       delay_in,
  input  logic                              cfg_we,
  input  logic [ffdl_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [ffdl_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [SAMPLE_BITS-1:0]     sample_out
);

  localparam int SB = SAMPLE_BITS;
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int FW = (FB_DEPTH > 1) ? $clog2(FB_DEPTH) : 1;
  localparam int DW = (AW + 8 > 24) ? AW + 8 : 24;
  localparam int CW = SB + 4;
  localparam int A1 = SB + 14;
  localparam int A2 = SB + 22;
  localparam int A3 = SB + 30;
  localparam int PW = SB + 18;
  localparam int BW = SB + 40;

  localparam logic [DW-1:0] DMIN = DW'(512);
  localparam logic [DW-1:0] DMAX = DW'(STORE_DEPTH - 2) << 8;
  localparam logic [AW:0]   DEPTH_X = (AW+1)'(STORE_DEPTH);
  localparam logic signed [BW-1:0] SMAX = BW'((64'd1 << (SB - 1)) - 64'd1);
  localparam logic signed [BW-1:0] SMIN = -SMAX - BW'(1);

  function automatic logic signed [SB-1:0] sat_v(input logic signed [BW-1:0] v);
    logic signed [BW-1:0] r;
    r = v;
    if (v > SMAX) r = SMAX;
    if (v < SMIN) r = SMIN;
    return r[SB-1:0];
  endfunction

  // configuration
  logic [23:0] fixed_delay;
  logic [16:0] feedback_level;
  logic        per_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      fixed_delay    <= ffdl_pkg::FIXED_DELAY_RST;
      feedback_level <= '0;
      per_sample     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        ffdl_pkg::REG_FIXED_DELAY:    fixed_delay    <= cfg_wdata[23:0];
        ffdl_pkg::REG_FEEDBACK_LEVEL: feedback_level <= cfg_wdata[16:0];
        ffdl_pkg::REG_PER_SAMPLE:     per_sample     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // positions and clear sweep
  logic [AW-1:0] wpos, clr_idx;
  logic [FW-1:0] fpos;

  always_ff @(posedge clk) begin
    if (rst) begin
      wpos    <= '0;
      fpos    <= '0;
      clr_idx <= '0;
    end else begin
      if (cmd.clr_wr) begin
        clr_idx <= stat.clr_last ? '0 : clr_idx + AW'(1);
      end
      if (cmd.fb_wr) begin
        wpos <= (wpos == AW'(STORE_DEPTH - 1)) ? '0 : wpos + AW'(1);
        fpos <= (fpos == FW'(FB_DEPTH - 1)) ? '0 : fpos + FW'(1);
      end
    end
  end

  assign stat.clr_last = (clr_idx == AW'(STORE_DEPTH - 1));

  // input capture
  logic signed [SB-1:0] smp;
  logic [23:0]          dly;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      smp <= sample_in;
      dly <= per_sample ? delay_in : fixed_delay;
    end
  end

  // delay clamp and split into whole samples and fraction
  logic [DW-1:0] d_ext, d_cl, d_sh;
  logic [7:0]    t_raw;
  logic [AW-1:0] back_c;
  logic [AW-1:0] back;
  logic [7:0]    t;

  always_comb begin
    d_ext = DW'(dly);
    d_cl  = d_ext;
    if (d_ext < DMIN) d_cl = DMIN;
    if (d_ext > DMAX) d_cl = DMAX;
    d_sh   = d_cl >> 8;
    t_raw  = d_cl[7:0];
    back_c = d_sh[AW-1:0];
  end

  // feedback memory
  logic signed [SB-1:0] fb_mem [FB_DEPTH];
  logic signed [SB-1:0] fb_rdata;
  logic signed [SB-1:0] fb_wval;
  logic [FW-1:0]        fb_addr;
  logic                 fb_clr;

  assign fb_clr  = cmd.clr_wr && cmd.clr_fb_en &&
                   ({1'b0, clr_idx} < (AW+1)'(FB_DEPTH));
  assign fb_addr = fb_clr ? clr_idx[FW-1:0] : fpos;

  always_ff @(posedge clk) begin
    if (fb_clr || cmd.fb_wr) begin
      fb_mem[fb_addr] <= fb_clr ? '0 : fb_wval;
    end
    if (cmd.fb_rd) begin
      fb_rdata <= fb_mem[fb_addr];
    end
  end

  // delay memory, single port
  logic signed [SB-1:0] dmem [STORE_DEPTH];
  logic signed [SB-1:0] dm_rdata, dm_wdata;
  logic [AW-1:0]        dm_addr, rd_addr, off;
  logic [AW:0]          diff;
  logic                 dm_we;

  always_comb begin
    case (cmd.rd_sel)
      ffdl_pkg::TAP_Y0: off = back + AW'(1);
      ffdl_pkg::TAP_Y1: off = back;
      ffdl_pkg::TAP_Y2: off = back - AW'(1);
      ffdl_pkg::TAP_Y3: off = back - AW'(2);
      default:          off = back;
    endcase
    diff = {1'b0, wpos} - {1'b0, off};
    if (diff[AW]) diff = diff + DEPTH_X;
    rd_addr = diff[AW-1:0];
  end

  assign dm_we    = cmd.clr_wr || cmd.wr_x;
  assign dm_wdata = cmd.clr_wr ? '0 : sat_v(BW'(smp) + BW'(fb_rdata));
  assign dm_addr  = cmd.clr_wr ? clr_idx : (cmd.wr_x ? wpos : rd_addr);

  always_ff @(posedge clk) begin
    if (dm_we) begin
      dmem[dm_addr] <= dm_wdata;
    end
    if (cmd.rd_en) begin
      dm_rdata <= dmem[dm_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_x) begin
      if (t_raw != 8'd0) begin
        back <= back_c + AW'(1);
        t    <= 8'd0 - t_raw;
      end else begin
        back <= back_c;
        t    <= 8'd0;
      end
    end
  end

  // neighbors
  logic signed [SB-1:0] y0, y1, y2, y3;

  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      case (cmd.cap_sel)
        ffdl_pkg::TAP_Y0: y0 <= dm_rdata;
        ffdl_pkg::TAP_Y1: y1 <= dm_rdata;
        ffdl_pkg::TAP_Y2: y2 <= dm_rdata;
        ffdl_pkg::TAP_Y3: y3 <= dm_rdata;
        default: ;
      endcase
    end
  end

  // Catmull-Rom, Horner form over t, one multiply per step
  logic signed [CW-1:0] y0e, y1e, y2e, y3e, c1, c2, c3, dy;
  logic signed [8:0]    ts;

  always_comb begin
    y0e = CW'(y0);
    y1e = CW'(y1);
    y2e = CW'(y2);
    y3e = CW'(y3);
    dy  = y1e - y2e;
    c1  = y2e - y0e;
    c2  = (y0e <<< 1) - ((y1e <<< 2) + y1e) + (y2e <<< 2) - y3e;
    c3  = (dy <<< 1) + dy + y3e - y0e;
    ts  = $signed({1'b0, t});
  end

  logic signed [A1-1:0] acc1;
  logic signed [A2-1:0] acc2;
  logic signed [A3-1:0] acc3, rsh;
  logic signed [SB-1:0] res;
  logic signed [PW-1:0] prod, prnd;
  logic [16:0]          lvl;

  assign lvl  = (feedback_level > ffdl_pkg::LEVEL_UNITY) ? ffdl_pkg::LEVEL_UNITY
                                                         : feedback_level;
  // round half up at 2^-25
  assign rsh  = (acc3 + (A3'(1) <<< 24)) >>> 25;
  assign prnd = (prod + (PW'(1) <<< 15)) >>> 16;
  assign fb_wval = sat_v(BW'(prnd));

  always_ff @(posedge clk) begin
    if (cmd.mul1) acc1 <= (A1'(c2) <<< 8) + A1'(c3) * A1'(ts);
    if (cmd.mul2) acc2 <= A2'(acc1) * A2'(ts) + (A2'(c1) <<< 16);
    if (cmd.mul3) acc3 <= A3'(acc2) * A3'(ts);
    if (cmd.res_ld) res <= sat_v(BW'(y1) + BW'(rsh));
    if (cmd.fbk_mul) prod <= PW'(res) * PW'($signed({1'b0, lvl}));
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) sample_out <= res;
  end

  assign stat.out_busy = out_valid && !out_ready;

endmodule
